// ----- rtl/rste_pkg.sv -----
`default_nettype none
package rste_pkg;

    // action codes
    localparam logic [1:0] ACT_LOAD   = 2'd0;
    localparam logic [1:0] ACT_ADD    = 2'd1;
    localparam logic [1:0] ACT_TOPPLE = 2'd2;

    localparam logic [7:0] CRITICAL    = 8'd4;
    localparam logic [7:0] TOPPLE_LOSS = 8'd2;
    localparam logic [7:0] CELL_MAX    = 8'd255;

    localparam int LEVEL_W = 13;

    typedef struct packed {
        logic [1:0] action;
        logic [5:0] row;
        logic [5:0] col;
        logic [1:0] load_value;
        logic       row_step_up;
        logic       col_step_up;
    } t_cmd;

    typedef struct packed {
        logic [1:0]         spill;
        logic               toppled;
        logic [LEVEL_W-1:0] queue_level;
        logic               queue_overflow;
    } t_res;

    // saturating increment of a grain count
    function automatic logic [7:0] bump(input logic [7:0] v);
        return (v == CELL_MAX) ? CELL_MAX : v + 8'd1;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/random_sandpile_toppling_engine_top.sv -----
`default_nettype none
// Channel   Direction  Handshake                 Payload
// command   in         start && !busy            i_cmd  (t_cmd)
// result    out        o_strobe, one cycle only  o_res  (t_res)
//
// One command word at a time: busy holds from accept until the result
// strobe. Load and add go through S_LOAD or S_ADD; a spare code, an
// off-grid cell or a topple on an empty queue go straight to S_DONE. A
// topple pops in S_SRC_RD, stops on a stale entry in S_SRC, else does a
// read-modify-write of source and neighbours and re-pushes a critical source.
// Synchronous active-low reset clears the sequencer and the queue
// pointers; memories need no clearing. The result side cannot stall.
module random_sandpile_toppling_engine_top
    import rste_pkg::*;
#(
    parameter int GRID_SIDE   = 64,
    parameter int QUEUE_DEPTH = 4096
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic start,
    output logic      busy,
    input  wire t_cmd i_cmd,
    output logic      o_strobe,
    output t_res      o_res
);

    localparam int RW    = $clog2(GRID_SIDE);            // coordinate width
    localparam int XW    = ((RW > 6) ? RW : 6) + 1;      // compare width
    localparam int CELLS = GRID_SIDE * GRID_SIDE;
    localparam int AW    = $clog2(CELLS);                // grid address width
    localparam int EW    = 2 * RW;                       // queue entry {row, col}
    localparam int QW    = $clog2(QUEUE_DEPTH);
    localparam int CNW   = $clog2(QUEUE_DEPTH + 1);

    localparam logic [RW-1:0] EDGE_HI = RW'(GRID_SIDE - 1);

    // sequencer states
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_LOAD   = 4'd1;
    localparam logic [3:0] S_ADD    = 4'd2;
    localparam logic [3:0] S_SRC_RD = 4'd3;
    localparam logic [3:0] S_SRC    = 4'd4;
    localparam logic [3:0] S_NR     = 4'd5;
    localparam logic [3:0] S_NC     = 4'd6;
    localparam logic [3:0] S_SELF   = 4'd7;
    localparam logic [3:0] S_DONE   = 4'd8;

    function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] r,
                                                 input logic [RW-1:0] c);
        return AW'(r) * AW'(GRID_SIDE) + AW'(c);
    endfunction

    logic [3:0]     r_state, n_state;
    t_cmd           r_cmd;
    logic [RW-1:0]  r_r, r_c;          // cell under work
    logic           r_src_crit;        // source still critical after topple
    logic [1:0]     r_lost;
    logic           r_toppled;
    logic           r_ovf;
    logic [QW-1:0]  r_head, r_tail;
    logic [CNW-1:0] r_count;

    // grid memory ports
    logic          cell_we;
    logic [AW-1:0] cell_waddr, cell_raddr;
    logic [7:0]    cell_wdata, cell_rdata;

    // queue memory ports
    logic          push;
    logic [EW-1:0] push_data;
    logic [EW-1:0] q_rdata;

    // command coordinates, range checked against the grid side
    logic [XW-1:0] in_row_x, in_col_x;
    logic          in_grid;
    logic [RW-1:0] in_r, in_c;

    assign in_row_x = XW'(i_cmd.row);
    assign in_col_x = XW'(i_cmd.col);
    assign in_grid  = (in_row_x < XW'(GRID_SIDE)) && (in_col_x < XW'(GRID_SIDE));
    assign in_r     = RW'(in_row_x);
    assign in_c     = RW'(in_col_x);

    // popped entry
    logic [RW-1:0] q_r, q_c;
    assign q_r = q_rdata[EW-1:RW];
    assign q_c = q_rdata[RW-1:0];

    // neighbours of the source cell
    logic [RW-1:0] nr_r, nc_c;
    logic          nr_ok, nc_ok;
    assign nr_r  = r_cmd.row_step_up ? r_r + RW'(1) : r_r - RW'(1);
    assign nc_c  = r_cmd.col_step_up ? r_c + RW'(1) : r_c - RW'(1);
    assign nr_ok = r_cmd.row_step_up ? (r_r != EDGE_HI) : (r_r != '0);
    assign nc_ok = r_cmd.col_step_up ? (r_c != EDGE_HI) : (r_c != '0);

    logic [7:0] bumped;
    assign bumped = bump(cell_rdata);

    rste_ram #(
        .WIDTH (8),
        .DEPTH (CELLS)
    ) u_cells (
        .i_clk   (i_clk),
        .i_we    (cell_we),
        .i_waddr (cell_waddr),
        .i_wdata (cell_wdata),
        .i_raddr (cell_raddr),
        .o_rdata (cell_rdata)
    );

    // read port parked on the head: the entry is ready in the cycle after accept
    rste_ram #(
        .WIDTH (EW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_we    (push && (r_count < CNW'(QUEUE_DEPTH))),
        .i_waddr (r_tail),
        .i_wdata (push_data),
        .i_raddr (r_head),
        .o_rdata (q_rdata)
    );

    // memory port selection and next state
    always_comb begin
        n_state    = r_state;
        cell_we    = 1'b0;
        cell_waddr = cell_addr(r_r, r_c);
        cell_wdata = bumped;
        cell_raddr = cell_addr(in_r, in_c);
        push       = 1'b0;
        push_data  = {r_r, r_c};
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    // load and add ignore off-grid cells
                    case (i_cmd.action)
                        ACT_LOAD:   n_state = in_grid ? S_LOAD : S_DONE;
                        ACT_ADD:    n_state = in_grid ? S_ADD : S_DONE;
                        ACT_TOPPLE: n_state = (r_count != '0) ? S_SRC_RD : S_DONE;
                        default:    n_state = S_DONE;
                    endcase
                end
            end
            S_LOAD: begin
                cell_we    = 1'b1;
                cell_wdata = {6'd0, r_cmd.load_value};
                n_state    = S_DONE;
            end
            S_ADD: begin
                cell_we = 1'b1;
                push    = (bumped >= CRITICAL);
                n_state = S_DONE;
            end
            S_SRC_RD: begin
                cell_raddr = cell_addr(q_r, q_c);
                n_state    = S_SRC;
            end
            S_SRC: begin
                cell_raddr = cell_addr(nr_r, r_c);
                if (cell_rdata >= CRITICAL) begin
                    cell_we    = 1'b1;
                    cell_wdata = cell_rdata - TOPPLE_LOSS;
                    n_state    = S_NR;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_NR: begin
                cell_raddr = cell_addr(r_r, nc_c);
                cell_waddr = cell_addr(nr_r, r_c);
                cell_we    = nr_ok;
                push       = nr_ok && (bumped >= CRITICAL);
                push_data  = {nr_r, r_c};
                n_state    = S_NC;
            end
            S_NC: begin
                cell_waddr = cell_addr(r_r, nc_c);
                cell_we    = nc_ok;
                push       = nc_ok && (bumped >= CRITICAL);
                push_data  = {r_r, nc_c};
                n_state    = S_SELF;
            end
            S_SELF: begin
                push    = r_src_crit;
                n_state = S_DONE;
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // sequencer and queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_SRC_RD) begin
                r_head  <= (r_head == QW'(QUEUE_DEPTH - 1)) ? '0 : r_head + QW'(1);
                r_count <= r_count - CNW'(1);
            end else if (push && (r_count < CNW'(QUEUE_DEPTH))) begin
                r_tail  <= (r_tail == QW'(QUEUE_DEPTH - 1)) ? '0 : r_tail + QW'(1);
                r_count <= r_count + CNW'(1);
            end
        end
    end

    // working registers and result word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lost    <= '0;
            r_toppled <= 1'b0;
            r_ovf     <= 1'b0;
        end else begin
            if (r_state == S_IDLE && start) begin
                r_cmd     <= i_cmd;
                r_r       <= in_r;
                r_c       <= in_c;
                r_lost    <= '0;
                r_toppled <= 1'b0;
                r_ovf     <= 1'b0;
            end
            if (r_state == S_SRC_RD) begin
                r_r <= q_r;
                r_c <= q_c;
            end
            if (r_state == S_SRC && cell_rdata >= CRITICAL) begin
                r_toppled  <= 1'b1;
                r_src_crit <= ((cell_rdata - TOPPLE_LOSS) >= CRITICAL);
                r_lost     <= 2'(!nr_ok) + 2'(!nc_ok);
            end
            if (push && (r_count >= CNW'(QUEUE_DEPTH))) begin
                r_ovf <= 1'b1;
            end
        end
    end

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = (r_state == S_DONE);

    always_comb begin
        o_res.spill          = r_lost;
        o_res.toppled        = r_toppled;
        o_res.queue_level    = LEVEL_W'(r_count);
        o_res.queue_overflow = r_ovf;
    end

    // queue never holds more than its depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNW'(QUEUE_DEPTH))
        else $error("queue count above depth");

    // grains are only lost by a cell that toppled
    a_lost_needs_topple: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_res.spill != 2'd0) |-> o_res.toppled)
        else $error("lost grains without topple");

    // count moves by at most one entry a cycle
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_count == $past(r_count) ||
                            r_count == $past(r_count) + CNW'(1) ||
                            r_count + CNW'(1) == $past(r_count)))
        else $error("queue count jumped");

    // an accepted word keeps the block busy in the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accept did not raise busy");

endmodule
`default_nettype wire

// ----- rtl/rste_ram.sv -----
`default_nettype none
module rste_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire
